// ----- hdl/stq_pkg.sv -----
// shared constants for the sorted timer queue
`timescale 1ns / 1ps
package stq_pkg;
	// default sizes
	localparam int DEPTH_DEF     = 16;
	localparam int TIME_BITS_DEF = 32;
	// field widths
	localparam int DELAY_W = 31;
	localparam int TAG_W   = 16;
	localparam int KIND_W  = 2;
	// most timers reported for one tick
	localparam int MAX_FIRE = 16;
	// result kinds
	localparam logic [KIND_W-1:0] KIND_ENQ   = 2'd0;
	localparam logic [KIND_W-1:0] KIND_FULL  = 2'd1;
	localparam logic [KIND_W-1:0] KIND_FIRED = 2'd2;
	// operation codes
	localparam logic FUNC_ENQ  = 1'b0;
	localparam logic FUNC_TICK = 1'b1;
endpackage

// ----- hdl/sorted_timer_queue_unit.sv -----
// sorted timer queue: ordered deadline store in a circular memory
`timescale 1ns / 1ps
// Timer queue of DEPTH entries, kept in order of expiry in one synchronous
// memory used as a circular buffer. An enqueue (func 0) walks the queue from
// the head, reading each entry from memory and then comparing or shifting it,
// finds its place and carries the displaced entries one slot back; its result
// is loaded once the walk reaches the tail slot and the output is free, and it
// always gives one result. A rejected enqueue gives its result once the output
// is free. A tick (func 1) advances the time and pops expired entries from the
// head, at most MAX_FIRE per tick, reading each entry and then comparing it;
// the last result of a tick has last set. A tick with nothing expired gives no
// result. One item is worked on at a time; a new item is taken while the
// previous result still waits in the output register.
module sorted_timer_queue_unit #(
	parameter int DEPTH     = stq_pkg::DEPTH_DEF,
	parameter int TIME_BITS = stq_pkg::TIME_BITS_DEF
) (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        in_valid,
	output logic                        in_ready,
	input  logic                        func,
	input  logic [stq_pkg::DELAY_W-1:0] delay,
	input  logic [stq_pkg::TAG_W-1:0]   tag,
	output logic                        out_valid,
	input  logic                        out_ready,
	output logic [stq_pkg::KIND_W-1:0]  kind,
	output logic [stq_pkg::TAG_W-1:0]   fired_tag,
	output logic                        last
);
	import stq_pkg::*;

	localparam int AW = $clog2(DEPTH);
	localparam int CW = $clog2(DEPTH + 1);
	localparam int EW = TIME_BITS + TAG_W;
	localparam int FW = $clog2(MAX_FIRE + 1);

	localparam logic [2:0] S_IDLE    = 3'd0;
	localparam logic [2:0] S_REJ     = 3'd1;
	localparam logic [2:0] S_INS_RD  = 3'd2;
	localparam logic [2:0] S_INS_CMP = 3'd3;
	localparam logic [2:0] S_TK_RD   = 3'd4;
	localparam logic [2:0] S_TK_CMP  = 3'd5;
	localparam logic [2:0] S_TK_END  = 3'd6;

	logic [2:0]           state_q;
	logic [TIME_BITS-1:0] now_q;
	logic [AW-1:0]        head_q;
	logic [CW-1:0]        count_q;
	logic [CW-1:0]        idx_q;
	logic                 srch_q;
	logic [EW-1:0]        new_q;
	logic [EW-1:0]        carry_q;
	logic                 pend_v_q;
	logic [TAG_W-1:0]     pend_tag_q;
	logic [FW-1:0]        fired_q;
	logic [EW-1:0]        rd_q;
	logic                 out_valid_q;
	logic [KIND_W-1:0]    kind_q;
	logic [TAG_W-1:0]     tag_q;
	logic                 last_q;

	logic [EW-1:0] mem [DEPTH];

	logic                 mem_we;
	logic                 mem_re;
	logic [AW-1:0]        mem_wa;
	logic [AW-1:0]        mem_ra;
	logic [EW-1:0]        mem_wd;
	logic [AW:0]          addr_sum;
	logic [AW-1:0]        ins_addr;
	logic [TIME_BITS-1:0] rd_dl;
	logic [TIME_BITS-1:0] ins_diff;
	logic [TIME_BITS-1:0] exp_diff;
	logic                 rd_after_new;
	logic                 rd_expired;
	logic                 out_free;
	logic                 out_load;
	logic                 in_xfer;

	assign in_xfer  = in_valid && in_ready;
	assign in_ready = (state_q == S_IDLE);
	assign out_free = !out_valid_q || out_ready;

	// physical slot of the walk index
	always_comb begin
		addr_sum = {1'b0, head_q} + {1'b0, idx_q[AW-1:0]};
		if (addr_sum >= (AW+1)'(DEPTH)) begin
			addr_sum = addr_sum - (AW+1)'(DEPTH);
		end
		ins_addr = addr_sum[AW-1:0];
	end

	// wrap-aware compares against the entry just read
	assign rd_dl        = rd_q[EW-1:TAG_W];
	assign ins_diff     = new_q[EW-1:TAG_W] - rd_dl;
	assign rd_after_new = ins_diff[TIME_BITS-1];
	assign exp_diff     = now_q - rd_dl;
	assign rd_expired   = !exp_diff[TIME_BITS-1];

	// a result enters the output register
	always_comb begin
		case (state_q)
			S_REJ:    out_load = out_free;
			S_INS_RD: out_load = (idx_q == count_q) && out_free;
			S_TK_CMP: out_load = rd_expired && pend_v_q && out_free;
			S_TK_END: out_load = pend_v_q && out_free;
			default:  out_load = 1'b0;
		endcase
	end

	// memory port control
	always_comb begin
		mem_we = 1'b0;
		mem_re = 1'b0;
		mem_wa = ins_addr;
		mem_ra = ins_addr;
		mem_wd = new_q;
		case (state_q)
			S_INS_RD: begin
				if (idx_q == count_q) begin
					mem_we = out_free;
					mem_wd = srch_q ? new_q : carry_q;
				end else begin
					mem_re = 1'b1;
				end
			end
			S_INS_CMP: begin
				if (srch_q) begin
					mem_we = rd_after_new;
					mem_wd = new_q;
				end else begin
					mem_we = 1'b1;
					mem_wd = carry_q;
				end
			end
			S_TK_RD: begin
				mem_ra = head_q;
				mem_re = (count_q != '0) && (fired_q != FW'(MAX_FIRE));
			end
			default: begin
				mem_we = 1'b0;
			end
		endcase
	end

	// entry memory
	always_ff @(posedge clk) begin
		if (mem_we) begin
			mem[mem_wa] <= mem_wd;
		end
		if (mem_re) begin
			rd_q <= mem[mem_ra];
		end
	end

	// sequencer
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			now_q       <= '0;
			head_q      <= '0;
			count_q     <= '0;
			idx_q       <= '0;
			srch_q      <= 1'b0;
			pend_v_q    <= 1'b0;
			fired_q     <= '0;
			out_valid_q <= 1'b0;
		end else begin
			if (out_load) begin
				out_valid_q <= 1'b1;
			end else if (out_valid_q && out_ready) begin
				out_valid_q <= 1'b0;
			end
			case (state_q)
				S_IDLE: begin
					if (in_xfer) begin
						idx_q    <= '0;
						srch_q   <= 1'b1;
						fired_q  <= '0;
						pend_v_q <= 1'b0;
						new_q    <= {TIME_BITS'(now_q + TIME_BITS'(delay)), tag};
						if (func == FUNC_TICK) begin
							now_q   <= now_q + 1'b1;
							state_q <= S_TK_RD;
						end else if (count_q == CW'(DEPTH)) begin
							state_q <= S_REJ;
						end else begin
							state_q <= S_INS_RD;
						end
					end
				end
				S_REJ: begin
					if (out_free) begin
						kind_q  <= KIND_FULL;
						tag_q   <= '0;
						last_q  <= 1'b1;
						state_q <= S_IDLE;
					end
				end
				S_INS_RD: begin
					if (idx_q == count_q) begin
						// tail slot takes the new or the carried entry
						if (out_free) begin
							count_q <= count_q + 1'b1;
							kind_q  <= KIND_ENQ;
							tag_q   <= '0;
							last_q  <= 1'b1;
							state_q <= S_IDLE;
						end
					end else begin
						state_q <= S_INS_CMP;
					end
				end
				S_INS_CMP: begin
					if (!srch_q || rd_after_new) begin
						carry_q <= rd_q;
						srch_q  <= 1'b0;
					end
					idx_q   <= idx_q + 1'b1;
					state_q <= S_INS_RD;
				end
				S_TK_RD: begin
					state_q <= mem_re ? S_TK_CMP : S_TK_END;
				end
				S_TK_CMP: begin
					if (!rd_expired) begin
						state_q <= S_TK_END;
					end else if (!pend_v_q || out_free) begin
						// previous fired entry is not the last one
						if (pend_v_q) begin
							kind_q <= KIND_FIRED;
							tag_q  <= pend_tag_q;
							last_q <= 1'b0;
						end
						pend_v_q   <= 1'b1;
						pend_tag_q <= rd_q[TAG_W-1:0];
						head_q     <= (head_q == AW'(DEPTH - 1)) ? '0 : head_q + 1'b1;
						count_q    <= count_q - 1'b1;
						fired_q    <= fired_q + 1'b1;
						state_q    <= S_TK_RD;
					end
				end
				S_TK_END: begin
					if (!pend_v_q) begin
						state_q <= S_IDLE;
					end else if (out_free) begin
						kind_q   <= KIND_FIRED;
						tag_q    <= pend_tag_q;
						last_q   <= 1'b1;
						pend_v_q <= 1'b0;
						state_q  <= S_IDLE;
					end
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

	assign out_valid = out_valid_q;
	assign kind      = kind_q;
	assign fired_tag = tag_q;
	assign last      = last_q;

`ifndef SYNTHESIS
	// occupancy never exceeds the memory
	assert property (@(posedge clk) disable iff (!arst_n) count_q <= CW'(DEPTH))
		else $error("queue count above depth");
	// a tick reports no more than its limit
	assert property (@(posedge clk) disable iff (!arst_n) fired_q <= FW'(MAX_FIRE))
		else $error("too many fired timers on one tick");
	// a non-fired result carries no tag
	assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && kind != KIND_FIRED |-> fired_tag == '0)
		else $error("tag on non-fired result");
	// a rejection only happens on a full queue
	assert property (@(posedge clk) disable iff (!arst_n)
		state_q == S_REJ |-> count_q == CW'(DEPTH))
		else $error("reject with room left");
`endif
endmodule
